FILE: hdl/lstp_pkg.sv
// Shared constants, types and the CORDIC arc table for the laser scan point converter.
package lstp_pkg;

	// Scan geometry
	localparam int MAX_BEAMS  = 4096;
	localparam int ANGLE_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_BEAMS + 1);

	// Angle resolution cut: keep only the top ANGLE_BITS of the 16-bit angle
	localparam int CUT = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
	localparam logic [15:0] ANGLE_MASK = 16'(32'hFFFF << CUT);

	// CORDIC sizing: x, y in Q30, z in turn/2^24
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int XY_W         = 33;
	localparam int Z_W          = 26;
	localparam logic signed [XY_W-1:0] CORDIC_X0 = XY_W'(64'sd652032874);

	// Shared multiplier operand width
	localparam int MUL_W = 18;

	// Configuration register indexes
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_START_ANGLE = 2'd0;
	localparam reg_idx_t REG_ANGLE_STEP  = 2'd1;
	localparam reg_idx_t REG_RANGE_LIMIT = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_TRIG,
		ST_MULX,
		ST_MULY,
		ST_OUT
	} seq_state_t;

	// atan(2^-i) in turn/2^24
	function automatic logic signed [Z_W-1:0] arc_at(input logic [STEP_W-1:0] i);
		logic signed [Z_W-1:0] a;
		case (i)
			4'd0:    a = Z_W'(2097152);
			4'd1:    a = Z_W'(1238021);
			4'd2:    a = Z_W'(654136);
			4'd3:    a = Z_W'(332050);
			4'd4:    a = Z_W'(166669);
			4'd5:    a = Z_W'(83416);
			4'd6:    a = Z_W'(41718);
			4'd7:    a = Z_W'(20860);
			4'd8:    a = Z_W'(10430);
			4'd9:    a = Z_W'(5215);
			4'd10:   a = Z_W'(2608);
			4'd11:   a = Z_W'(1304);
			4'd12:   a = Z_W'(652);
			4'd13:   a = Z_W'(326);
			4'd14:   a = Z_W'(163);
			4'd15:   a = Z_W'(81);
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

FILE: hdl/lstp_cordic.sv
// Iterative rotation CORDIC: one shift-add step per cycle, Q15 cosine and sine out.
module lstp_cordic (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic [15:0]              angle,
	output logic                     done,
	output logic signed [15:0]       cos_q,
	output logic signed [15:0]       sin_q
);
	import lstp_pkg::*;

	logic                     busy_q;
	logic                     rnd_q;
	logic                     done_q;
	logic [STEP_W-1:0]        cnt_q;
	logic signed [XY_W-1:0]   x_q;
	logic signed [XY_W-1:0]   y_q;
	logic signed [Z_W-1:0]    z_q;
	logic                     flip_q;

	// Round Q30 to Q15 with clamp, negate for a half-turn fold
	function automatic logic signed [15:0] q15(input logic signed [XY_W-1:0] v,
			input logic neg);
		logic signed [XY_W:0] t;
		logic signed [15:0]   c;
		t = (XY_W+1)'(v) + (XY_W+1)'(32'sd16384);
		t = t >>> 15;
		if (t > 32767)
			c = 16'sd32767;
		else if (t < -32767)
			c = -16'sd32767;
		else
			c = t[15:0];
		return neg ? -c : c;
	endfunction

	// Angle fold into [-quarter, +quarter]
	logic [15:0]        a_cut;
	logic signed [16:0] sa;
	logic signed [16:0] sa_fold;
	logic               flip_in;

	always_comb begin
		a_cut   = angle & ANGLE_MASK;
		sa      = 17'($signed(a_cut));
		flip_in = (sa > 17'sd16384) || (sa < -17'sd16384);
		if (!flip_in)
			sa_fold = sa;
		else if (sa > 17'sd0)
			sa_fold = sa - 17'sd32768;
		else
			sa_fold = sa + 17'sd32768;
	end

	// One micro-rotation
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  arc;

	assign xs  = x_q >>> cnt_q;
	assign ys  = y_q >>> cnt_q;
	assign arc = arc_at(cnt_q);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= rnd_q;
			rnd_q  <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == STEP_W'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= CORDIC_X0;
			y_q    <= '0;
			z_q    <= Z_W'(sa_fold) <<< 8;
			flip_q <= flip_in;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - arc;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + arc;
			end
		end
		if (rnd_q) begin
			cos_q <= q15(x_q, flip_q);
			sin_q <= q15(y_q, flip_q);
		end
	end

	assign done = done_q;

endmodule

FILE: hdl/laser_scan_to_points.sv
// Top level: laser scan samples in, beam points with scan statistics out.
//
// Each accepted range sample yields exactly one result. A kept sample passes through these
// steps from one input transfer to the next: the sample is taken, the beam angle is formed on
// the shared 18x18 multiplier, the iterative CORDIC runs its micro-rotations, the result is
// rounded to Q15 and handed back to the sequencer, the multiplier is reused for x and y, and
// the result is presented until the output takes it. A discarded or overflowed sample goes
// from intake straight to presenting its result.
// The block takes no new sample until its result has been transferred; configuration writes
// belong to idle periods.
module laser_scan_to_points (
	input  logic         clk,
	input  logic         arst_n,
	// configuration
	input  logic         cfg_we,
	input  lstp_pkg::reg_idx_t cfg_index,
	input  logic [15:0]  cfg_wdata,
	// sample stream
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [15:0] range_sample
	input  logic [1:0]   s_tuser,   // [0] sample_finite, [1] scan_start
	// point stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// [11:0] beam_index, [27:12] beam_range, [43:28] beam_angle, [60:44] point_x,
	// [77:61] point_y, [93:78] min_kept, [109:94] max_kept, [111:110] zero
	output logic [111:0] m_tdata,
	output logic [1:0]   m_tuser    // [0] kept, [1] index_overflow
);
	import lstp_pkg::*;

	// Configuration registers
	logic signed [15:0] start_angle_q;
	logic signed [15:0] angle_step_q;
	logic [15:0]        range_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_angle_q <= '0;
			angle_step_q  <= '0;
			range_limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_ANGLE: start_angle_q <= cfg_wdata;
				REG_ANGLE_STEP:  angle_step_q  <= cfg_wdata;
				REG_RANGE_LIMIT: range_limit_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Sequencer
	seq_state_t state_q;
	seq_state_t state_d;
	logic       in_xfer;
	logic       out_xfer;
	logic       cordic_go;
	logic       cordic_done;
	logic       keep_cur;
	logic       keep_q;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_xfer) state_d = keep_cur ? ST_ANGLE : ST_OUT;
			ST_ANGLE: state_d = ST_TRIG;
			ST_TRIG:  if (cordic_done) state_d = ST_MULX;
			ST_MULX:  state_d = ST_MULY;
			ST_MULY:  state_d = ST_OUT;
			ST_OUT:   if (out_xfer) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Sample intake: index, keep decision, running min and max
	logic [IDX_W-1:0] index_count_q;
	logic [15:0]      min_seen_q;
	logic [15:0]      max_seen_q;
	logic [IDX_W-1:0] idx_cur;
	logic             over_cur;
	logic [15:0]      min_base;
	logic [15:0]      max_base;
	logic [15:0]      r_in;

	assign r_in     = s_tdata[15:0];
	assign idx_cur  = s_tuser[1] ? '0 : index_count_q;
	assign over_cur = idx_cur >= IDX_W'(MAX_BEAMS);
	assign keep_cur = !over_cur && s_tuser[0] && (r_in < range_limit_q);
	assign min_base = s_tuser[1] ? 16'hFFFF : min_seen_q;
	assign max_base = s_tuser[1] ? 16'h0000 : max_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_count_q <= '0;
			min_seen_q    <= 16'hFFFF;
			max_seen_q    <= '0;
		end else if (in_xfer) begin
			index_count_q <= over_cur ? idx_cur : idx_cur + 1'b1;
			min_seen_q    <= (keep_cur && r_in < min_base) ? r_in : min_base;
			max_seen_q    <= (keep_cur && r_in > max_base) ? r_in : max_base;
		end
	end

	logic [15:0]      r_q;
	logic [IDX_W-1:0] idx_q;
	logic             over_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= 1'b0;
			over_q <= 1'b0;
		end else if (in_xfer) begin
			keep_q <= keep_cur;
			over_q <= over_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			r_q   <= r_in;
			idx_q <= idx_cur;
		end
	end

	// Shared multiplier: angle step times index, then range times cos and sin
	logic signed [MUL_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]   mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	logic signed [2*MUL_W-1:0] pt_sum;
	logic [16:0]               pt_val;
	logic [15:0]               angle_sum;
	logic signed [15:0]        cos_q;
	logic signed [15:0]        sin_q;

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		cordic_go = 1'b0;
		unique case (state_q)
			ST_ANGLE: begin
				mul_a     = MUL_W'(angle_step_q);
				mul_b     = MUL_W'({1'b0, idx_q});
				cordic_go = 1'b1;
			end
			ST_MULX: begin
				mul_a = MUL_W'({1'b0, r_q});
				mul_b = MUL_W'(cos_q);
			end
			ST_MULY: begin
				mul_a = MUL_W'({1'b0, r_q});
				mul_b = MUL_W'(sin_q);
			end
			default: ;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		m_tvalid = (state_q == ST_OUT);
	end

	assign mul_p     = mul_a * mul_b;
	assign pt_sum    = mul_p + (2*MUL_W)'(16384);
	assign pt_val    = pt_sum[31:15];
	assign angle_sum = start_angle_q + mul_p[15:0];

	lstp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cordic_go),
		.angle  (angle_sum),
		.done   (cordic_done),
		.cos_q  (cos_q),
		.sin_q  (sin_q)
	);

	// Result registers
	logic [15:0] angle_q;
	logic [16:0] px_q;
	logic [16:0] py_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_ANGLE)
			angle_q <= angle_sum;
		if (state_q == ST_MULX)
			px_q <= pt_val;
		if (state_q == ST_MULY)
			py_q <= pt_val;
	end

	// Output packing; range, angle and point fields of a discarded sample read as zero
	logic [11:0] beam_index;

	assign beam_index = over_q ? 12'd0 : 12'(idx_q);
	assign m_tdata = {2'b00, max_seen_q, min_seen_q,
		keep_q ? py_q : 17'd0,
		keep_q ? px_q : 17'd0,
		keep_q ? angle_q : 16'd0,
		keep_q ? r_q : 16'd0,
		beam_index};
	assign m_tuser = {over_q, keep_q};

	// Checks
	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("input ready while a result is pending");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		index_count_q <= IDX_W'(MAX_BEAMS))
		else $error("beam index ran past its bound");

	a_kept_not_over: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(keep_q && over_q))
		else $error("overflowed sample marked kept");

	a_kept_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && keep_q) |-> (min_seen_q <= r_q && r_q <= max_seen_q))
		else $error("kept range outside scan min/max");

endmodule
